// File: rtl/core/ppep_pkg.sv
// Package for the page preload and eviction policy engine.
// Holds widths, codes, controller states and the controller/datapath structs.
// No dependencies.
package ppep_pkg;

    localparam int MAX_PAGES = 256;
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int PAGE_W    = 9;
    localparam int SCAN_W    = 13;
    localparam int MEM_W     = 40;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MIB_SHIFT = 20;

    typedef enum logic [1:0] {
        CMD_IDLE   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_VIEW   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_UNLOAD = 2'd2
    } t_act;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_COUNT = 2'd0,
        CFG_AHEAD      = 2'd1,
        CFG_BEHIND     = 2'd2,
        CFG_LIMIT      = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BACK,
        S_FWD,
        S_LIMIT,
        S_EV_SCAN,
        S_EV_DRAIN,
        S_EV_SEL,
        S_EV_APPLY,
        S_REP_APPLY
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SETUP,
        OP_BACK,
        OP_FWD,
        OP_EV_INIT,
        OP_EV_SCAN,
        OP_EV_RDSZ,
        OP_EV_APPLY,
        OP_REP_RD,
        OP_REP_APPLY,
        OP_VIEW_WR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic emit;
        t_act act;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic hit;
        logic back_more;
        logic fwd_more;
        logic over;
        logic ev_more;
        logic have;
        logic pno_ok;
    } t_stat;

endpackage

// File: rtl/core/page_preload_evict_policy.sv
// Page preload and eviction policy engine, top level.
// Joins ppep_ctrl and ppep_dp. Depends on ppep_pkg.
//
// One command word is taken when start is high and busy low; exactly one
// result word follows, shown for one cycle with o_valid high, and must be
// taken then: there is no back-pressure. Page flags and ticks are visited
// one entry per cycle by the two preload scans and, when eviction runs, by
// the eviction scan over all pages; no new command word is taken while busy
// is high. Configuration may be written while idle.
module page_preload_evict_policy (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppep_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ppep_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_cmd,
    input  logic signed [9:0]              i_view_offset,
    input  logic [8:0]                     i_view_spread,
    input  logic [8:0]                     i_page_number,
    input  logic [31:0]                    i_page_bytes,
    input  logic                           i_load_error,
    input  logic [31:0]                    i_view_time,
    output logic                           o_valid,
    output logic [1:0]                     o_action,
    output logic [8:0]                     o_target_page,
    output logic                           o_did_work
);
    import ppep_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    ppep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    ppep_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_view_offset (i_view_offset),
        .i_view_spread (i_view_spread),
        .i_page_number (i_page_number),
        .i_page_bytes  (i_page_bytes),
        .i_load_error  (i_load_error),
        .i_view_time   (i_view_time),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_action      (o_action),
        .o_target_page (o_target_page),
        .o_did_work    (o_did_work)
    );

endmodule

// File: rtl/core/ppep_ctrl.sv
// Controller state machine of the policy engine.
// Sequences the scans, eviction and reports. Depends on ppep_pkg.
module ppep_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ppep_pkg::t_stat i_stat,
    output ppep_pkg::t_ctl  o_ctl,
    output logic           busy
);
    import ppep_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.cmd == CMD_IDLE) n_state = S_BACK;
                else if (i_stat.cmd == CMD_REPORT && i_stat.pno_ok) n_state = S_REP_APPLY;
                else n_state = S_IDLE;
            end
            S_BACK: begin
                if (i_stat.back_more && i_stat.hit) n_state = S_IDLE;
                else if (!i_stat.back_more) n_state = S_FWD;
            end
            S_FWD: begin
                if (i_stat.fwd_more && i_stat.hit) n_state = S_IDLE;
                else if (!i_stat.fwd_more) n_state = S_LIMIT;
            end
            S_LIMIT: begin
                n_state = i_stat.over ? S_EV_SCAN : S_IDLE;
            end
            S_EV_SCAN: begin
                if (!i_stat.ev_more) n_state = S_EV_DRAIN;
            end
            S_EV_DRAIN: n_state = S_EV_SEL;
            S_EV_SEL: begin
                n_state = i_stat.have ? S_EV_APPLY : S_IDLE;
            end
            S_EV_APPLY:  n_state = S_IDLE;
            S_REP_APPLY: n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.op   = OP_NONE;
        o_ctl.emit = 1'b0;
        o_ctl.act  = ACT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) o_ctl.op = OP_LATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.cmd)
                    CMD_IDLE:   o_ctl.op = OP_SETUP;
                    CMD_REPORT: begin
                        o_ctl.op   = OP_REP_RD;
                        o_ctl.emit = !i_stat.pno_ok;
                    end
                    CMD_VIEW: begin
                        o_ctl.op   = OP_VIEW_WR;
                        o_ctl.emit = 1'b1;
                    end
                    default: o_ctl.emit = 1'b1;
                endcase
            end
            S_BACK: begin
                o_ctl.op = OP_BACK;
                if (i_stat.back_more && i_stat.hit) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.act  = ACT_LOAD;
                end
            end
            S_FWD: begin
                o_ctl.op = OP_FWD;
                if (i_stat.fwd_more && i_stat.hit) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.act  = ACT_LOAD;
                end
            end
            S_LIMIT: begin
                if (i_stat.over) o_ctl.op = OP_EV_INIT;
                else o_ctl.emit = 1'b1;
            end
            S_EV_SCAN:  o_ctl.op = OP_EV_SCAN;
            S_EV_DRAIN: o_ctl.op = OP_NONE;
            S_EV_SEL: begin
                if (i_stat.have) o_ctl.op = OP_EV_RDSZ;
                else o_ctl.emit = 1'b1;
            end
            S_EV_APPLY: begin
                o_ctl.op   = OP_EV_APPLY;
                o_ctl.emit = 1'b1;
                o_ctl.act  = ACT_UNLOAD;
            end
            S_REP_APPLY: begin
                o_ctl.op   = OP_REP_APPLY;
                o_ctl.emit = 1'b1;
            end
            default: o_ctl.op = OP_NONE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/core/ppep_dp.sv
// Datapath of the policy engine: config registers, page flags, size and
// tick memories, scan counter, eviction pipeline, memory total, result word.
// Depends on ppep_pkg.
module ppep_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ppep_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ppep_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [1:0]                       i_cmd,
    input  logic signed [9:0]                i_view_offset,
    input  logic [8:0]                       i_view_spread,
    input  logic [8:0]                       i_page_number,
    input  logic [31:0]                      i_page_bytes,
    input  logic                             i_load_error,
    input  logic [31:0]                      i_view_time,
    input  ppep_pkg::t_ctl                   i_ctl,
    output ppep_pkg::t_stat                  o_stat,
    output logic                             o_valid,
    output logic [1:0]                       o_action,
    output logic [8:0]                       o_target_page,
    output logic                             o_did_work
);
    import ppep_pkg::*;

    localparam logic signed [SCAN_W-1:0] ONE_S = SCAN_W'(1);

    // configuration
    logic [PAGE_W-1:0] r_page_count;
    logic [7:0]        r_ahead;
    logic [7:0]        r_behind;
    logic [15:0]       r_limit;

    // latched command word
    t_cmd              r_cmd;
    logic signed [9:0] r_off;
    logic [8:0]        r_spread;
    logic [8:0]        r_pno;
    logic [31:0]       r_bytes;
    logic              r_err;
    logic [31:0]       r_tick;

    // page state
    logic [MAX_PAGES-1:0] r_loaded;
    logic [MAX_PAGES-1:0] r_failed;
    logic [MAX_PAGES-1:0] r_tick_ok;
    logic [WORD_W-1:0]    size_mem [MAX_PAGES];
    logic [WORD_W-1:0]    tick_mem [MAX_PAGES];
    logic [WORD_W-1:0]    r_size_rd;
    logic [WORD_W-1:0]    r_tick_rd;
    logic [MEM_W-1:0]     r_total;

    // scan
    logic signed [SCAN_W-1:0] r_no, r_first, r_last, r_fstart;
    logic                     r_pv, r_pcand, r_ptok;
    logic [PAGE_W-1:0]        r_pno_ev;
    logic                     r_have;
    logic [PAGE_W-1:0]        r_old_no;
    logic [WORD_W-1:0]        r_old_tick;

    // result word
    logic        r_valid;
    t_act        r_action;
    logic [8:0]  r_target;
    logic        r_work;

    logic [PAGE_W-1:0]        cnt;
    logic signed [SCAN_W-1:0] cnt_s, off_s, first_raw, vend, last_raw;
    logic signed [SCAN_W-1:0] no_m1, pno_m1;
    logic [IDX_W-1:0]         idx, pidx, oidx;
    logic                     pno_in, in_win;
    logic [WORD_W-1:0]        cur_tick;
    logic [MEM_W:0]           sub_v, add_v;
    logic [MEM_W-1:0]         after_sub;
    logic [MEM_W-1:0]         limit_bytes;
    logic [PAGE_W-1:0]        old_m1;

    always_comb begin
        cnt       = (r_page_count > PAGE_W'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : r_page_count;
        cnt_s     = SCAN_W'(cnt);
        off_s     = SCAN_W'(r_off);
        first_raw = off_s - SCAN_W'(r_behind);
        vend      = off_s + SCAN_W'(r_spread) - ONE_S;
        last_raw  = vend + SCAN_W'(r_ahead);
        no_m1     = r_no - ONE_S;
        idx       = no_m1[IDX_W-1:0];
        pno_m1    = SCAN_W'(r_pno) - ONE_S;
        pidx      = pno_m1[IDX_W-1:0];
        old_m1    = r_old_no - PAGE_W'(1);
        oidx      = old_m1[IDX_W-1:0];
        pno_in    = (r_pno != 9'd0) && (r_pno <= cnt);
        in_win    = (r_no >= r_first) && (r_no <= r_last);
        cur_tick  = r_ptok ? r_tick_rd : '0;
        limit_bytes = MEM_W'({r_limit, {MIB_SHIFT{1'b0}}});
        sub_v     = {1'b0, r_total} - (MEM_W+1)'(r_size_rd);
        after_sub = sub_v[MEM_W] ? '0 : sub_v[MEM_W-1:0];
        add_v     = {1'b0, after_sub} + (MEM_W+1)'(r_bytes);
    end

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.hit       = !r_loaded[idx] && !r_failed[idx];
        o_stat.back_more = (r_no >= r_first);
        o_stat.fwd_more  = (r_no <= r_last);
        o_stat.over      = (r_total > limit_bytes);
        o_stat.ev_more   = (r_no <= cnt_s);
        o_stat.have      = r_have;
        o_stat.pno_ok    = pno_in && r_loaded[pidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= '0;
            r_ahead      <= '0;
            r_behind     <= '0;
            r_limit      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PAGE_COUNT: r_page_count <= i_cfg_data[PAGE_W-1:0];
                CFG_AHEAD:      r_ahead      <= i_cfg_data[7:0];
                CFG_BEHIND:     r_behind     <= i_cfg_data[7:0];
                CFG_LIMIT:      r_limit      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // command word and scan registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_LATCH) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_off    <= i_view_offset;
            r_spread <= i_view_spread;
            r_pno    <= i_page_number;
            r_bytes  <= i_page_bytes;
            r_err    <= i_load_error;
            r_tick   <= i_view_time;
        end
        case (i_ctl.op)
            OP_SETUP: begin
                r_first  <= (first_raw < ONE_S) ? ONE_S : first_raw;
                r_last   <= (last_raw > cnt_s) ? cnt_s : last_raw;
                r_fstart <= (vend < ONE_S) ? ONE_S : vend;
                r_no     <= (off_s > cnt_s) ? cnt_s : off_s;
            end
            OP_BACK: begin
                if (!o_stat.back_more) r_no <= r_fstart;
                else if (!o_stat.hit) r_no <= r_no - ONE_S;
            end
            OP_FWD: begin
                if (o_stat.fwd_more && !o_stat.hit) r_no <= r_no + ONE_S;
            end
            OP_EV_INIT: r_no <= ONE_S;
            OP_EV_SCAN: begin
                if (o_stat.ev_more) r_no <= r_no + ONE_S;
            end
            default: ;
        endcase
    end

    // eviction pipeline: tick read, then oldest compare
    always_ff @(posedge i_clk) begin
        r_pcand  <= r_loaded[idx] && !in_win;
        r_ptok   <= r_tick_ok[idx];
        r_pno_ev <= r_no[PAGE_W-1:0];
        if (r_pv && r_pcand && (!r_have || cur_tick < r_old_tick)) begin
            r_old_no   <= r_pno_ev;
            r_old_tick <= cur_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_pv <= (i_ctl.op == OP_EV_SCAN) && o_stat.ev_more;
            if (i_ctl.op == OP_EV_INIT) r_have <= 1'b0;
            else if (r_pv && r_pcand) r_have <= 1'b1;
        end
    end

    // flags and memory total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= '0;
            r_failed  <= '0;
            r_tick_ok <= '0;
            r_total   <= '0;
        end else begin
            case (i_ctl.op)
                OP_BACK: begin
                    if (o_stat.back_more && o_stat.hit) r_loaded[idx] <= 1'b1;
                end
                OP_FWD: begin
                    if (o_stat.fwd_more && o_stat.hit) r_loaded[idx] <= 1'b1;
                end
                OP_EV_APPLY: begin
                    r_loaded[oidx] <= 1'b0;
                    r_total        <= after_sub;
                end
                OP_REP_APPLY: begin
                    if (r_err) begin
                        r_loaded[pidx] <= 1'b0;
                        r_failed[pidx] <= 1'b1;
                        r_total        <= after_sub;
                    end else begin
                        r_total <= add_v[MEM_W] ? {MEM_W{1'b1}} : add_v[MEM_W-1:0];
                    end
                end
                OP_VIEW_WR: begin
                    if (pno_in) r_tick_ok[pidx] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // size memory; a page gets size zero when its load is issued
    always_ff @(posedge i_clk) begin
        if (((i_ctl.op == OP_BACK) && o_stat.back_more && o_stat.hit) ||
            ((i_ctl.op == OP_FWD) && o_stat.fwd_more && o_stat.hit)) begin
            size_mem[idx] <= '0;
        end else if (i_ctl.op == OP_EV_APPLY) begin
            size_mem[oidx] <= '0;
        end else if (i_ctl.op == OP_REP_APPLY) begin
            size_mem[pidx] <= r_err ? '0 : r_bytes;
        end
        r_size_rd <= size_mem[(i_ctl.op == OP_EV_RDSZ) ? oidx : pidx];
    end

    // tick memory
    always_ff @(posedge i_clk) begin
        if ((i_ctl.op == OP_VIEW_WR) && pno_in) begin
            tick_mem[pidx] <= r_tick;
        end
        r_tick_rd <= tick_mem[idx];
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
        end
        if (i_ctl.emit) begin
            r_action <= i_ctl.act;
            r_work   <= (i_ctl.act == ACT_LOAD);
            case (i_ctl.act)
                ACT_LOAD:   r_target <= r_no[8:0];
                ACT_UNLOAD: r_target <= r_old_no;
                default:    r_target <= '0;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_action      = r_action;
    assign o_target_page = r_target;
    assign o_did_work    = r_work;

endmodule

// File: bench/page_preload_evict_policy_tb.sv
// Self-checking testbench for page_preload_evict_policy.
// Directed table then random command words, checked against a behavioural predictor.
// Depends on ppep_pkg and the RTL top level.
module page_preload_evict_policy_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ppep_pkg::*;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [9:0]  offset;
        logic [8:0]         spread;
        logic [8:0]         pno;
        logic [31:0]        bytes;
        logic               err;
        logic [31:0]        tick;
    } t_word;

    typedef struct packed {
        logic [1:0] act;
        logic [8:0] page;
        logic       work;
    } t_res;

    typedef struct {
        t_word w;
        logic  has_exp;
        t_res  exp;
    } t_row;

    logic        i_clk, i_rst_n, i_cfg_we, start, busy;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic [1:0]  i_cmd;
    logic signed [9:0] i_view_offset;
    logic [8:0]  i_view_spread, i_page_number;
    logic [31:0] i_page_bytes, i_view_time;
    logic        i_load_error;
    logic        o_valid, o_did_work;
    logic [1:0]  o_action;
    logic [8:0]  o_target_page;

    page_preload_evict_policy u_dut (.*);

    // predictor state
    logic [8:0]  pc_cnt;
    logic [7:0]  pc_ahead, pc_behind;
    logic [15:0] pc_limit;
    logic        pg_loaded [MAX_PAGES];
    logic        pg_failed [MAX_PAGES];
    logic [31:0] pg_size [MAX_PAGES];
    logic [31:0] pg_tick [MAX_PAGES];
    logic [39:0] mem_total;

    t_res  policy_q[$];
    t_res  fixed_q[$];
    logic  fixed_flag_q[$];
    int    errors, mism, accepted, results, idle_cyc;
    int    n_load, n_unload;
    logic  in_flight;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res policy_step(t_word w);
        t_res r;
        int cnt, first, last, no, found, oldest;
        logic [31:0] otick;
        logic [40:0] sum;
        r = '0;
        cnt = (pc_cnt > MAX_PAGES) ? MAX_PAGES : pc_cnt;
        found = 0;
        if (w.cmd == CMD_IDLE) begin
            first = int'(w.offset) - int'(pc_behind);
            last = int'(w.offset) + int'(w.spread) - 1 + int'(pc_ahead);
            if (first < 1) first = 1;
            if (last > cnt) last = cnt;
            for (no = int'(w.offset); no >= first && found == 0; no--)
                if (no >= 1 && no <= cnt && !pg_loaded[no-1] && !pg_failed[no-1]) found = no;
            for (no = int'(w.offset) + int'(w.spread) - 1; no <= last && found == 0; no++)
                if (no >= 1 && no <= cnt && !pg_loaded[no-1] && !pg_failed[no-1]) found = no;
            if (found != 0) begin
                pg_loaded[found-1] = 1;
                r.act = ACT_LOAD; r.page = 9'(found); r.work = 1'b1;
            end else if (mem_total > ({24'd0, pc_limit} << MIB_SHIFT)) begin
                oldest = 0; otick = 0;
                for (no = 1; no <= cnt; no++) begin
                    if (!(no >= first && no <= last) && pg_loaded[no-1]) begin
                        if (oldest == 0 || pg_tick[no-1] < otick) begin
                            oldest = no; otick = pg_tick[no-1];
                        end
                    end
                end
                if (oldest != 0) begin
                    mem_total = (mem_total > pg_size[oldest-1]) ?
                                mem_total - pg_size[oldest-1] : '0;
                    pg_size[oldest-1] = 0;
                    pg_loaded[oldest-1] = 0;
                    r.act = ACT_UNLOAD; r.page = 9'(oldest);
                end
            end
        end else if (w.cmd == CMD_REPORT) begin
            if (w.pno >= 1 && w.pno <= cnt && pg_loaded[w.pno-1]) begin
                mem_total = (mem_total > pg_size[w.pno-1]) ? mem_total - pg_size[w.pno-1] : '0;
                if (w.err) begin
                    pg_size[w.pno-1] = 0;
                    pg_loaded[w.pno-1] = 0;
                    pg_failed[w.pno-1] = 1;
                end else begin
                    pg_size[w.pno-1] = w.bytes;
                    sum = mem_total + w.bytes;
                    mem_total = sum[40] ? '1 : sum[39:0];
                end
            end
        end else if (w.cmd == CMD_VIEW) begin
            if (w.pno >= 1 && w.pno <= cnt) pg_tick[w.pno-1] = w.tick;
        end
        return r;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, int val);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = 16'(val);
        case (idx)
            CFG_PAGE_COUNT: pc_cnt = 9'(val);
            CFG_AHEAD:      pc_ahead = 8'(val);
            CFG_BEHIND:     pc_behind = 8'(val);
            default:        pc_limit = 16'(val);
        endcase
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic wait_drained();
        while (policy_q.size() != 0 || in_flight) @(negedge i_clk);
        repeat (2 * MAX_PAGES + 20) @(negedge i_clk);
    endtask

    task automatic send_word(t_word w, logic has_exp, t_res exp, int gap);
        repeat (gap) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cmd = w.cmd; i_view_offset = w.offset; i_view_spread = w.spread;
        i_page_number = w.pno; i_page_bytes = w.bytes; i_load_error = w.err;
        i_view_time = w.tick;
        start = 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        policy_q.push_back(policy_step(w));
        fixed_q.push_back(exp);
        fixed_flag_q.push_back(has_exp);
        in_flight = 1;
        @(negedge i_clk);
        start = 0;
    endtask

    function automatic t_word rand_word(int cnt);
        t_word w;
        int k;
        w.tick = $urandom; w.bytes = $urandom; w.err = ($urandom_range(0, 5) == 0);
        k = $urandom_range(0, 9);
        w.cmd = (k < 5) ? CMD_IDLE : (k < 8) ? CMD_REPORT : (k < 9) ? CMD_VIEW : CMD_UNUSED;
        if ($urandom_range(0, 9) == 0) w.cmd = 2'($urandom);
        w.offset = ($urandom_range(0, 15) == 0) ? 10'($urandom)
                                                : 10'($urandom_range(0, cnt + 2) - 1);
        w.spread = ($urandom_range(0, 15) == 0) ? 9'($urandom) : 9'($urandom_range(1, 6));
        w.pno = ($urandom_range(0, 15) == 0) ? 9'($urandom) : 9'($urandom_range(1, cnt + 1));
        if ($urandom_range(0, 3) == 0) w.bytes = $urandom_range(0, 3 << 20);
        return w;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res got, e, f;
        logic hf;
        if (i_rst_n && o_valid) begin
            got = '{o_action, o_target_page, o_did_work};
            results++;
            if (policy_q.size() == 0) begin
                errors++;
                if (mism++ < 10) $display("unexpected result word %h", got);
            end else begin
                e = policy_q.pop_front();
                f = fixed_q.pop_front();
                hf = fixed_flag_q.pop_front();
                if (hf && f !== e) begin
                    errors++;
                    if (mism++ < 10) $display("table row disagrees: table %h pred %h", f, e);
                end
                if (got.act !== e.act || got.page !== e.page || got.work !== e.work) begin
                    errors++;
                    if (mism++ < 10)
                        $display("mismatch: exp act %0d page %0d work %0d, got %0d %0d %0d",
                                 e.act, e.page, e.work, got.act, got.page, got.work);
                end
                if (e.act == ACT_LOAD) n_load++;
                if (e.act == ACT_UNLOAD) n_unload++;
            end
            in_flight = 0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (o_valid || (start && !busy)) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_word w;
        t_res none;
        int i, ph, cnt;
        none = '0;
        errors = 0; mism = 0; results = 0; idle_cyc = 0; in_flight = 0;
        n_load = 0; n_unload = 0;
        pc_cnt = 0; pc_ahead = 0; pc_behind = 0; pc_limit = 0; mem_total = 0;
        for (i = 0; i < MAX_PAGES; i++) begin
            pg_loaded[i] = 0; pg_failed[i] = 0; pg_size[i] = 0; pg_tick[i] = 0;
        end
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = CFG_PAGE_COUNT; i_cfg_data = 0; start = 0;
        i_cmd = CMD_IDLE; i_view_offset = 0; i_view_spread = 1; i_page_number = 1;
        i_page_bytes = 0; i_load_error = 0; i_view_time = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        // after reset: no pages, nothing to do
        rows.push_back('{'{CMD_IDLE, 10'sd1, 9'd1, 9'd1, 0, 0, 0}, 1, none});
        rows.push_back('{'{CMD_UNUSED, -10'sd255, 9'd256, 9'd256, '1, 1, '1}, 1, none});
        foreach (rows[k]) send_word(rows[k].w, rows[k].has_exp, rows[k].exp, 0);
        wait_drained();

        cfg_write(CFG_PAGE_COUNT, 8);
        cfg_write(CFG_AHEAD, 2);
        cfg_write(CFG_BEHIND, 1);
        cfg_write(CFG_LIMIT, 0);
        rows.delete();
        rows.push_back('{'{CMD_IDLE, 10'sd3, 9'd2, 9'd0, 0, 0, 0}, 1, '{ACT_LOAD, 9'd3, 1'b1}});
        rows.push_back('{'{CMD_IDLE, 10'sd3, 9'd2, 9'd0, 0, 0, 0}, 1, '{ACT_LOAD, 9'd2, 1'b1}});
        rows.push_back('{'{CMD_REPORT, 10'sd0, 9'd1, 9'd3, '1, 0, 0}, 1, none});
        rows.push_back('{'{CMD_REPORT, 10'sd0, 9'd1, 9'd2, 32'd5, 1, 0}, 1, none});
        rows.push_back('{'{CMD_VIEW, 10'sd0, 9'd1, 9'd3, 0, 0, '1}, 1, none});
        rows.push_back('{'{CMD_VIEW, 10'sd0, 9'd1, 9'd0, 0, 0, 0}, 1, none});
        rows.push_back('{'{CMD_REPORT, 10'sd0, 9'd1, 9'd9, 32'd7, 0, 0}, 1, none});
        rows.push_back('{'{CMD_IDLE, 10'sd3, 9'd2, 9'd0, 0, 0, 0}, 0, none});
        rows.push_back('{'{CMD_IDLE, 10'sd3, 9'd2, 9'd0, 0, 0, 0}, 0, none});
        rows.push_back('{'{CMD_IDLE, 10'sd3, 9'd2, 9'd0, 0, 0, 0}, 0, none});
        rows.push_back('{'{CMD_IDLE, -10'sd255, 9'd256, 9'd0, 0, 0, 0}, 0, none});
        rows.push_back('{'{CMD_IDLE, 10'sd256, 9'd1, 9'd0, 0, 0, 0}, 0, none});
        rows.push_back('{'{CMD_IDLE, 10'sd7, 9'd1, 9'd0, 0, 0, 0}, 0, none});
        rows.push_back('{'{CMD_IDLE, 10'sd1, 9'd1, 9'd0, 0, 0, 0}, 0, none});
        foreach (rows[k]) send_word(rows[k].w, rows[k].has_exp, rows[k].exp, $urandom_range(0, 3));
        wait_drained();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cfg_write(CFG_PAGE_COUNT, 256); cfg_write(CFG_AHEAD, 255);
                         cfg_write(CFG_BEHIND, 255); cfg_write(CFG_LIMIT, 65535); end
                1: begin cfg_write(CFG_PAGE_COUNT, 12); cfg_write(CFG_AHEAD, 0);
                         cfg_write(CFG_BEHIND, 0); cfg_write(CFG_LIMIT, 0); end
                5: begin cfg_write(CFG_PAGE_COUNT, 300); cfg_write(CFG_LIMIT, 1); end
                default: begin
                    cfg_write(CFG_PAGE_COUNT, $urandom_range(2, 40));
                    cfg_write(CFG_AHEAD, $urandom_range(0, 4));
                    cfg_write(CFG_BEHIND, $urandom_range(0, 4));
                    cfg_write(CFG_LIMIT, $urandom_range(0, 3));
                end
            endcase
            cnt = (pc_cnt > MAX_PAGES) ? MAX_PAGES : pc_cnt;
            if (ph != 0 && ph != 5) cnt = (cnt > 40) ? 40 : cnt;
            for (i = 0; i < 250; i++) begin
                w = rand_word(cnt);
                if (i == 125) wait_drained();
                send_word(w, 0, none, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
            end
            wait_drained();
        end

        $display("%0d command words, %0d results, %0d loads, %0d unloads",
                 accepted, results, n_load, n_unload);
        if (errors == 0 && policy_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) if (i_rst_n && start && !busy) accepted++;
endmodule

// File: files.f
rtl/core/ppep_pkg.sv
rtl/core/ppep_ctrl.sv
rtl/core/ppep_dp.sv
rtl/core/page_preload_evict_policy.sv
bench/page_preload_evict_policy_tb.sv
